// ===== hw/rtl/sud_pkg.sv =====
// Package for the signed/unsigned integer divider.
// Holds widths, opcodes and the structs passed between the divider stages.
// Depends on nothing.
package sud_pkg;

  localparam int unsigned DataW = 64;
  localparam int unsigned HalfW = 32;
  localparam int unsigned NumCells = DataW;

  localparam logic [DataW-1:0] LowMask = {{(DataW-HalfW){1'b0}}, {HalfW{1'b1}}};

  typedef enum logic [1:0] {
    OP_UDIV32 = 2'd0,
    OP_SDIV32 = 2'd1,
    OP_UDIV64 = 2'd2,
    OP_SDIV64 = 2'd3
  } sud_op_e;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [DataW-1:0] dividend;
    logic [DataW-1:0] divisor;
  } sud_in_t;

  typedef struct packed {
    logic [DataW-1:0] quotient;
    logic [DataW-1:0] remainder;
    logic             divide_by_zero;
  } sud_out_t;

  typedef struct packed {
    logic wide;
    logic neg_q;
    logic neg_r;
    logic dbz;
  } sud_meta_t;

  typedef struct packed {
    logic             valid;
    sud_meta_t        meta;
    logic [DataW-1:0] rem;
    logic [DataW-1:0] nq;
    logic [DataW-1:0] d;
  } sud_stage_t;

endpackage

// ===== hw/rtl/sud_pre.sv =====
// Operand preparation stage: masks the operands, takes magnitudes and flags zero divisors.
// Depends on sud_pkg.
module sud_pre (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  sud_pkg::sud_in_t    in_i,
  output sud_pkg::sud_stage_t stage_o
);

  logic                       valid_q;
  sud_pkg::sud_meta_t         meta_d, meta_q;
  logic [sud_pkg::DataW-1:0]  an_d, ad_d, an_q, ad_q;

  always_comb begin
    logic                      wide;
    logic                      sgn;
    logic [sud_pkg::DataW-1:0] mask;
    logic [sud_pkg::DataW-1:0] n;
    logic [sud_pkg::DataW-1:0] d;
    logic                      nneg;
    logic                      dneg;
    wide = (in_i.opcode == sud_pkg::OP_UDIV64) || (in_i.opcode == sud_pkg::OP_SDIV64);
    sgn  = (in_i.opcode == sud_pkg::OP_SDIV32) || (in_i.opcode == sud_pkg::OP_SDIV64);
    mask = wide ? {sud_pkg::DataW{1'b1}} : sud_pkg::LowMask;
    n    = in_i.dividend & mask;
    d    = in_i.divisor & mask;
    nneg = sgn && (wide ? n[sud_pkg::DataW-1] : n[sud_pkg::HalfW-1]);
    dneg = sgn && (wide ? d[sud_pkg::DataW-1] : d[sud_pkg::HalfW-1]);
    an_d = nneg ? ((~n + 1'b1) & mask) : n;
    ad_d = dneg ? ((~d + 1'b1) & mask) : d;
    meta_d.wide  = wide;
    meta_d.neg_q = nneg ^ dneg;
    meta_d.neg_r = nneg;
    meta_d.dbz   = (d == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      meta_q <= meta_d;
      an_q   <= an_d;
      ad_q   <= ad_d;
    end
  end

  always_comb begin
    stage_o.valid = valid_q;
    stage_o.meta  = meta_q;
    stage_o.rem   = '0;
    stage_o.nq    = an_q;
    stage_o.d     = ad_q;
  end

endmodule

// ===== hw/rtl/sud_cell.sv =====
// One restoring shift-subtract step of the divider chain.
// Depends on sud_pkg.
module sud_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  sud_pkg::sud_stage_t stage_i,
  output sud_pkg::sud_stage_t stage_o
);

  sud_pkg::sud_stage_t       stage_d;
  logic                      valid_q;
  sud_pkg::sud_meta_t        meta_q;
  logic [sud_pkg::DataW-1:0] rem_q, nq_q, d_q;

  always_comb begin
    logic [sud_pkg::DataW-1:0] shifted;
    logic [sud_pkg::DataW:0]   diff;
    logic                      take;
    shifted = {stage_i.rem[sud_pkg::DataW-2:0], stage_i.nq[sud_pkg::DataW-1]};
    diff    = {stage_i.rem[sud_pkg::DataW-1], shifted} - {1'b0, stage_i.d};
    take    = !diff[sud_pkg::DataW];
    stage_d       = stage_i;
    stage_d.rem   = take ? diff[sud_pkg::DataW-1:0] : shifted;
    stage_d.nq    = {stage_i.nq[sud_pkg::DataW-2:0], take};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= stage_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      meta_q <= stage_d.meta;
      rem_q  <= stage_d.rem;
      nq_q   <= stage_d.nq;
      d_q    <= stage_d.d;
    end
  end

  always_comb begin
    stage_o.valid = valid_q;
    stage_o.meta  = meta_q;
    stage_o.rem   = rem_q;
    stage_o.nq    = nq_q;
    stage_o.d     = d_q;
  end

endmodule

// ===== hw/rtl/sud_post.sv =====
// Result stage: restores signs, applies the mode width and holds the output register.
// Depends on sud_pkg.
module sud_post (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  sud_pkg::sud_stage_t stage_i,
  output logic                valid_o,
  output sud_pkg::sud_out_t   out_o
);

  logic              valid_q;
  sud_pkg::sud_out_t out_d, out_q;

  always_comb begin
    logic [sud_pkg::DataW-1:0] mask;
    logic [sud_pkg::DataW-1:0] q;
    logic [sud_pkg::DataW-1:0] r;
    mask = stage_i.meta.wide ? {sud_pkg::DataW{1'b1}} : sud_pkg::LowMask;
    q    = stage_i.meta.neg_q ? (~stage_i.nq + 1'b1) : stage_i.nq;
    r    = stage_i.meta.neg_r ? (~stage_i.rem + 1'b1) : stage_i.rem;
    out_d.quotient       = stage_i.meta.dbz ? '0 : (q & mask);
    out_d.remainder      = r & mask;
    out_d.divide_by_zero = stage_i.meta.dbz;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= stage_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_q <= out_d;
    end
  end

  assign valid_o = valid_q;
  assign out_o   = out_q;

  ap_narrow_zero_ext: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && stage_i.valid && !stage_i.meta.wide |=>
      out_q.quotient[sud_pkg::DataW-1:sud_pkg::HalfW] == '0 &&
      out_q.remainder[sud_pkg::DataW-1:sud_pkg::HalfW] == '0)
    else $error("narrow result not zero-extended");

  ap_dbz_quotient: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && out_q.divide_by_zero |-> out_q.quotient == '0)
    else $error("divide by zero with nonzero quotient");

  ap_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !en_i |=> valid_q && $stable(out_q))
    else $error("waiting result changed before its transfer");

endmodule

// ===== hw/rtl/signed_unsigned_int_divider.sv =====
// Top level of the signed/unsigned 32/64-bit integer divider.
// Depends on sud_pkg, sud_pre, sud_cell and sud_post.
//
// Usage:
// An operand transfer on the input channel (in_valid_i, in_ready_o, in_data_i)
// carries an opcode, a dividend and a divisor. Each one yields exactly one
// result transfer on the output channel (out_valid_o, out_ready_i, out_data_o)
// with quotient, remainder and a divide-by-zero flag, in input order.
// The datapath is a chain of 64 identical restoring cells, one quotient bit
// per cell, between an operand preparation register and an output register.
// Throughput is one item per cycle: a new operand pair may be taken in every
// cycle, since each cell handles a different item at any time.
// Reset clears every stage valid bit, so the pipe comes up empty and ready.
// When the receiver stalls while a result is waiting, the whole chain holds
// and in_ready_o drops; an empty output register lets the chain move on.
module signed_unsigned_int_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  sud_pkg::sud_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output sud_pkg::sud_out_t out_data_o
);

  logic                advance;
  sud_pkg::sud_stage_t stages [sud_pkg::NumCells+1];

  assign advance    = !out_valid_o || out_ready_i;
  assign in_ready_o = advance;

  sud_pre u_pre (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (advance),
    .valid_i (in_valid_i),
    .in_i    (in_data_i),
    .stage_o (stages[0])
  );

  for (genvar g = 0; g < sud_pkg::NumCells; g++) begin : g_cell
    sud_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (advance),
      .stage_i (stages[g]),
      .stage_o (stages[g+1])
    );
  end

  sud_post u_post (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (advance),
    .stage_i (stages[sud_pkg::NumCells]),
    .valid_o (out_valid_o),
    .out_o   (out_data_o)
  );

  ap_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> stages[0].valid)
    else $error("accepted transfer did not enter the chain");

  ap_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(stages[0].valid) && $stable(stages[sud_pkg::NumCells].valid))
    else $error("chain moved during a stall");

  ap_last_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && stages[sud_pkg::NumCells].valid |=> out_valid_o)
    else $error("finished item lost before the output register");

endmodule
